// ----- design/pid_with_twiddle_tuning_assert.svh -----
// ----------------------------------------------------------------------------
// pid twiddle assertion macros
// concurrent check shorthands used by the pid twiddle top module
// ----------------------------------------------------------------------------
`ifndef PID_WITH_TWIDDLE_TUNING_ASSERT_SVH
`define PID_WITH_TWIDDLE_TUNING_ASSERT_SVH

// condition and consequence in the same cycle
`define PWT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define PWT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pwt_pkg.sv -----
// ----------------------------------------------------------------------------
// pwt_pkg
// types, constants and arithmetic helpers of the pid twiddle controller
// ----------------------------------------------------------------------------
package pwt_pkg;

    localparam int GAIN_COUNT = 3;
    localparam int CFG_IDX_W  = 3;

    localparam logic CMD_STEP = 1'b0;
    localparam logic CMD_INIT = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_START = 3'd0,
        CFG_KI_START = 3'd1,
        CFG_KD_START = 3'd2,
        CFG_TUNE_TOL = 3'd3,
        CFG_SETTLE   = 3'd4,
        CFG_EVAL     = 3'd5
    } t_cfg_idx;

    localparam logic [1:0] GAIN_P    = 2'd0;
    localparam logic [1:0] GAIN_I    = 2'd1;
    localparam logic [1:0] GAIN_D    = 2'd2;
    localparam logic [1:0] PREV_NONE = 2'd3;

    localparam logic [47:0] SCORE_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] TOL_RESET    = 32'd3277;
    localparam logic [15:0] SETTLE_RESET = 16'd100;
    localparam logic [15:0] EVAL_RESET   = 16'd400;

    // floor(m * RECIP_TEN / 2^35) == floor(m / 10) for any 32-bit m
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam logic signed [71:0] TERM_LIMIT     = 72'sh400_0000_0000;
    localparam logic signed [71:0] TERM_LIMIT_NEG = -TERM_LIMIT;
    localparam logic signed [47:0] SAT_HI         = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_LO         = 48'shFFFF_8000_0000;

    typedef logic signed [31:0] t_gain;
    typedef t_gain t_gain_arr [GAIN_COUNT];

    typedef struct packed {
        logic               command;
        logic signed [15:0] error_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive_value;
        logic signed [31:0] kp_now;
        logic signed [31:0] ki_now;
        logic signed [31:0] kd_now;
        logic               tuning_done;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] kp_start;
        logic signed [31:0] ki_start;
        logic signed [31:0] kd_start;
        logic [31:0]        tune_tolerance;
        logic [15:0]        settle_steps;
        logic [15:0]        eval_steps;
    } t_cfg_regs;

    typedef struct packed {
        logic stale;
        logic done;
    } t_tune_status;

    // signed divide by ten, truncated toward zero
    function automatic logic signed [31:0] div10_trunc(input logic signed [31:0] v);
        logic [31:0] mag_v;
        logic [63:0] prod;
        logic [31:0] quot;
        mag_v = v[31] ? (~v + 32'd1) : v;
        prod  = {32'd0, mag_v} * {32'd0, RECIP_TEN};
        quot  = {3'd0, prod[63:35]};
        return v[31] ? (32'd0 - quot) : quot;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[31:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[31:0];
        end
        return v[31:0];
    endfunction

    // q24.24 product floored to q16.16 and clamped to +-2^42
    function automatic logic signed [43:0] floor_clamp(input logic signed [71:0] p);
        logic signed [71:0] q;
        q = p >>> 8;
        if (q > TERM_LIMIT) begin
            return TERM_LIMIT[43:0];
        end else if (q < TERM_LIMIT_NEG) begin
            return TERM_LIMIT_NEG[43:0];
        end
        return q[43:0];
    endfunction

endpackage

// ----- design/pwt_tuner.sv -----
// ----------------------------------------------------------------------------
// pwt_tuner
// error state, saturating integral and twiddle gain tuner, one update a cycle if not stale
// ----------------------------------------------------------------------------
module pwt_tuner (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_update,
    input  logic                     i_cmd,
    input  logic signed [15:0]       i_err,
    input  logic [31:0]              i_sq,
    input  pwt_pkg::t_cfg_regs       i_cfg,
    input  logic                     i_cfg_wr,
    output pwt_pkg::t_gain_arr       o_gain,
    output logic signed [39:0]       o_integ,
    output logic signed [16:0]       o_diff,
    output pwt_pkg::t_tune_status    o_status
);

    pwt_pkg::t_gain_arr  r_gain, n_gain;
    pwt_pkg::t_gain_arr  r_delta, n_delta;
    pwt_pkg::t_gain_arr  r_start_tenth, n_start_tenth;
    logic signed [15:0]  r_last_error, n_last_error;
    logic signed [39:0]  r_integ, n_integ;
    logic [47:0]         r_best, n_best;
    logic [47:0]         r_wscore, n_wscore;
    logic [16:0]         r_phase, n_phase;
    logic [1:0]          r_gi, n_gi;
    logic [1:0]          r_prev, n_prev;
    logic                r_pd, n_pd;
    logic                r_stale, n_stale;
    logic                r_tune_on;
    logic signed [31:0]  r_tenth, n_tenth;

    logic signed [33:0]  w_delta_sum;
    logic                w_tune_next;
    logic [1:0]          w_k, w_k_next;
    logic signed [31:0]  w_gain_k, w_delta_k;
    logic signed [31:0]  w_g_plus, w_g_minus, w_d_up, w_d_dn;
    logic signed [35:0]  w_tenth_x10;
    logic signed [31:0]  w_tenth_away;
    logic [16:0]         w_inc, w_win;
    logic                w_wrap, w_scored, w_better;
    logic [48:0]         w_ws_sum;
    logic [47:0]         w_ws_new;
    logic signed [40:0]  w_integ_sum;
    logic signed [39:0]  w_integ_sat;
    logic                n_scale;

    assign w_delta_sum = 34'(r_delta[0]) + 34'(r_delta[1]) + 34'(r_delta[2]);
    assign w_tune_next = w_delta_sum > $signed({2'b00, i_cfg.tune_tolerance});

    assign w_k      = (r_gi == pwt_pkg::PREV_NONE) ? pwt_pkg::GAIN_P : r_gi;
    assign w_k_next = (w_k == pwt_pkg::GAIN_D) ? pwt_pkg::GAIN_P : w_k + 2'd1;
    assign w_gain_k  = r_gain[w_k];
    assign w_delta_k = r_delta[w_k];

    assign w_g_plus  = pwt_pkg::sat32(48'(w_gain_k) + 48'(w_delta_k));
    assign w_g_minus = pwt_pkg::sat32(48'(w_gain_k) - 48'(w_delta_k) - 48'(w_delta_k));
    // r_tenth holds a tenth of the delta of the current gain index
    assign w_d_up    = pwt_pkg::sat32(48'(w_delta_k) + 48'(r_tenth));
    // shrinking truncates toward zero, so the tenth taken off rounds away from zero
    assign w_tenth_x10  = (36'(r_tenth) <<< 3) + (36'(r_tenth) <<< 1);
    assign w_tenth_away = (w_tenth_x10 == 36'(w_delta_k)) ? r_tenth :
                          (w_delta_k[31] ? r_tenth - 32'sd1 : r_tenth + 32'sd1);
    assign w_d_dn    = w_delta_k - w_tenth_away;

    assign w_inc    = r_phase + 17'd1;
    assign w_win    = {1'b0, i_cfg.settle_steps} + {1'b0, i_cfg.eval_steps};
    assign w_wrap   = w_inc >= w_win;
    assign w_scored = !w_wrap && (w_inc > {1'b0, i_cfg.settle_steps});
    assign w_ws_sum = {1'b0, r_wscore} + {17'd0, i_sq};
    assign w_ws_new = !w_scored ? r_wscore :
                      (w_ws_sum[48] ? pwt_pkg::SCORE_MAX : w_ws_sum[47:0]);
    assign w_better = w_ws_new < r_best;

    assign w_integ_sum = 41'(r_integ) + 41'(i_err);
    assign w_integ_sat = (w_integ_sum[40] != w_integ_sum[39]) ?
                         (w_integ_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}}) :
                         w_integ_sum[39:0];

    assign o_diff   = 17'(i_err) - 17'(r_last_error);
    assign o_gain   = r_gain;
    assign o_integ  = r_integ;
    assign o_status = '{stale: r_stale, done: !w_tune_next};

    assign n_tenth          = pwt_pkg::div10_trunc(r_delta[w_k]);
    assign n_start_tenth[0] = pwt_pkg::div10_trunc(i_cfg.kp_start);
    assign n_start_tenth[1] = pwt_pkg::div10_trunc(i_cfg.ki_start);
    assign n_start_tenth[2] = pwt_pkg::div10_trunc(i_cfg.kd_start);

    always_comb begin
        n_gain       = r_gain;
        n_delta      = r_delta;
        n_last_error = r_last_error;
        n_integ      = r_integ;
        n_best       = r_best;
        n_wscore     = r_wscore;
        n_phase      = r_phase;
        n_gi         = r_gi;
        n_prev       = r_prev;
        n_pd         = r_pd;
        n_scale      = 1'b0;
        if (i_update) begin
            if (i_cmd == pwt_pkg::CMD_INIT) begin
                n_gain[0]    = i_cfg.kp_start;
                n_gain[1]    = i_cfg.ki_start;
                n_gain[2]    = i_cfg.kd_start;
                n_delta      = r_start_tenth;
                n_last_error = '0;
                n_integ      = '0;
                n_best       = pwt_pkg::SCORE_MAX;
                n_wscore     = '0;
                n_phase      = 17'd1;
                n_gi         = pwt_pkg::GAIN_P;
                n_prev       = pwt_pkg::PREV_NONE;
                n_pd         = 1'b0;
                n_scale      = 1'b1;
            end else begin
                n_last_error = i_err;
                n_integ      = w_integ_sat;
                if (r_tune_on) begin
                    n_phase  = w_wrap ? '0 : w_inc;
                    n_wscore = w_ws_new;
                    if (w_wrap) begin
                        // end of evaluation window
                        n_gi     = w_k;
                        n_wscore = '0;
                        priority if (r_prev != w_k) begin
                            if (w_better) begin
                                n_best = w_ws_new;
                            end
                            n_gain[w_k] = w_g_plus;
                            n_prev      = w_k;
                        end else if (w_better) begin
                            n_best       = w_ws_new;
                            n_delta[w_k] = w_d_up;
                            n_gi         = w_k_next;
                            n_pd         = 1'b0;
                            n_scale      = 1'b1;
                        end else if (!r_pd) begin
                            n_gain[w_k] = w_g_minus;
                            n_pd        = 1'b1;
                        end else begin
                            n_gain[w_k]  = w_g_plus;
                            n_delta[w_k] = w_d_dn;
                            n_gi         = w_k_next;
                            n_pd         = 1'b0;
                            n_scale      = 1'b1;
                        end
                    end
                end
            end
        end
        // tenth and delta-sum compare refresh in the cycle after deltas or config move
        n_stale = n_scale || i_cfg_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= '{default: '0};
            r_delta      <= '{default: '0};
            r_last_error <= '0;
            r_integ      <= '0;
            r_best       <= pwt_pkg::SCORE_MAX;
            r_wscore     <= '0;
            r_phase      <= 17'd1;
            r_gi         <= pwt_pkg::GAIN_P;
            r_prev       <= pwt_pkg::PREV_NONE;
            r_pd         <= 1'b0;
            r_stale      <= 1'b1;
        end else begin
            r_gain       <= n_gain;
            r_delta      <= n_delta;
            r_last_error <= n_last_error;
            r_integ      <= n_integ;
            r_best       <= n_best;
            r_wscore     <= n_wscore;
            r_phase      <= n_phase;
            r_gi         <= n_gi;
            r_prev       <= n_prev;
            r_pd         <= n_pd;
            r_stale      <= n_stale;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tenth       <= n_tenth;
        r_tune_on     <= w_tune_next;
        r_start_tenth <= n_start_tenth;
    end

endmodule

// ----- design/pwt_datapath.sv -----
// ----------------------------------------------------------------------------
// pwt_datapath
// pid products, floor and clamp, saturated drive sum and output register
// ----------------------------------------------------------------------------
module pwt_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic                  i_cmd,
    input  logic signed [15:0]    i_err,
    input  logic signed [16:0]    i_diff,
    input  pwt_pkg::t_gain_arr    i_gain,
    input  logic signed [39:0]    i_integ,
    input  logic                  i_done,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_out_ready,
    output pwt_pkg::t_out_item    o_item
);

    // stage a: terms of the request whose state update just landed
    logic                r_a_valid;
    logic                r_a_cmd;
    logic signed [15:0]  r_a_err;
    logic signed [16:0]  r_a_diff;

    // stage b: raw products
    logic                r_b_valid;
    logic                r_b_cmd;
    logic                r_b_done;
    pwt_pkg::t_gain_arr  r_b_gain;
    logic signed [47:0]  r_b_pp;
    logic signed [48:0]  r_b_pd;
    logic signed [51:0]  r_b_pih;
    logic signed [52:0]  r_b_pil;

    // stage c: floored and clamped terms
    logic                r_c_valid;
    logic                r_c_cmd;
    logic                r_c_done;
    pwt_pkg::t_gain_arr  r_c_gain;
    logic signed [43:0]  r_c_tp, r_c_ti, r_c_td;

    logic                r_out_valid;
    pwt_pkg::t_out_item  r_out, n_out;

    logic                w_out_free, w_c_free, w_b_free, w_a_free;
    logic signed [47:0]  w_pp;
    logic signed [48:0]  w_pd;
    logic signed [51:0]  w_pih;
    logic signed [52:0]  w_pil;
    logic signed [71:0]  w_prod_i;
    logic signed [45:0]  w_sum;
    logic signed [31:0]  w_drive;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_c_free   = !r_c_valid || w_out_free;
    assign w_b_free   = !r_b_valid || w_c_free;
    assign w_a_free   = !r_a_valid || w_b_free;
    assign o_ready    = w_a_free;
    assign o_valid    = r_out_valid;
    assign o_item     = r_out;

    // gains and integral are read straight from the tuner: nothing updates while a waits
    assign w_pp  = 48'(i_gain[pwt_pkg::GAIN_P]) * 48'(r_a_err);
    assign w_pd  = 49'(i_gain[pwt_pkg::GAIN_D]) * 49'(r_a_diff);
    assign w_pih = 52'(i_gain[pwt_pkg::GAIN_I]) * 52'($signed(i_integ[39:20]));
    assign w_pil = 53'(i_gain[pwt_pkg::GAIN_I]) * 53'($signed({1'b0, i_integ[19:0]}));

    assign w_prod_i = (72'(r_b_pih) <<< 20) + 72'(r_b_pil);

    assign w_sum   = 46'(r_c_tp) + 46'(r_c_ti) + 46'(r_c_td);
    assign w_drive = pwt_pkg::sat32(-48'(w_sum));

    always_comb begin
        n_out.drive_value = (r_c_cmd == pwt_pkg::CMD_INIT) ? '0 : w_drive;
        n_out.kp_now      = r_c_gain[pwt_pkg::GAIN_P];
        n_out.ki_now      = r_c_gain[pwt_pkg::GAIN_I];
        n_out.kd_now      = r_c_gain[pwt_pkg::GAIN_D];
        n_out.tuning_done = r_c_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_a_free) begin
                r_a_valid <= i_load;
            end
            if (w_b_free) begin
                r_b_valid <= r_a_valid;
            end
            if (w_c_free) begin
                r_c_valid <= r_b_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_free && i_load) begin
            r_a_cmd  <= i_cmd;
            r_a_err  <= i_err;
            r_a_diff <= i_diff;
        end
        if (w_b_free && r_a_valid) begin
            r_b_cmd  <= r_a_cmd;
            r_b_done <= i_done;
            r_b_gain <= i_gain;
            r_b_pp   <= w_pp;
            r_b_pd   <= w_pd;
            r_b_pih  <= w_pih;
            r_b_pil  <= w_pil;
        end
        if (w_c_free && r_b_valid) begin
            r_c_cmd  <= r_b_cmd;
            r_c_done <= r_b_done;
            r_c_gain <= r_b_gain;
            r_c_tp   <= pwt_pkg::floor_clamp(72'(r_b_pp));
            r_c_ti   <= pwt_pkg::floor_clamp(w_prod_i);
            r_c_td   <= pwt_pkg::floor_clamp(72'(r_b_pd));
        end
        if (w_out_free && r_c_valid) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- design/pid_with_twiddle_tuning.sv -----
// ----------------------------------------------------------------------------
// pid_with_twiddle_tuning
// fixed-point pid controller whose gains are tuned online by twiddle search
// ----------------------------------------------------------------------------
// path: input register, then datapath stages a, b and c, then the output register
// throughput: one request per cycle unless the output stalls; the tuner update stage holds
//   in the cycle after an initialize, a window end that rescales a delta, or a config
//   write, while the per-gain tenth and the delta-sum compare registers refresh
// reset: synchronous active low; config returns to defaults, gains and deltas to zero
`include "pid_with_twiddle_tuning_assert.svh"

module pid_with_twiddle_tuning (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pwt_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pwt_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pwt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    pwt_pkg::t_cfg_regs    r_cfg;
    logic                  r_i_valid;
    logic                  r_i_cmd;
    logic signed [15:0]    r_i_err;
    logic [31:0]           r_i_sq;

    logic                  w_cfg_wr;
    logic                  w_in_acc;
    logic                  w_i_adv;
    logic                  w_a_ready;
    logic signed [31:0]    w_sq_full;
    pwt_pkg::t_gain_arr    w_gain;
    logic signed [39:0]    w_integ;
    logic signed [16:0]    w_diff;
    pwt_pkg::t_tune_status w_status;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    assign w_i_adv    = r_i_valid && !w_status.stale && w_a_ready;
    assign o_in_ready = !r_i_valid || w_i_adv;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_sq_full  = 32'(i_in_data.error_sample) * 32'(i_in_data.error_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{kp_start: '0, ki_start: '0, kd_start: '0,
                       tune_tolerance: pwt_pkg::TOL_RESET,
                       settle_steps: pwt_pkg::SETTLE_RESET,
                       eval_steps: pwt_pkg::EVAL_RESET};
        end else if (w_cfg_wr) begin
            unique case (pwt_pkg::t_cfg_idx'(i_cfg_index))
                pwt_pkg::CFG_KP_START: r_cfg.kp_start       <= i_cfg_data;
                pwt_pkg::CFG_KI_START: r_cfg.ki_start       <= i_cfg_data;
                pwt_pkg::CFG_KD_START: r_cfg.kd_start       <= i_cfg_data;
                pwt_pkg::CFG_TUNE_TOL: r_cfg.tune_tolerance <= i_cfg_data;
                pwt_pkg::CFG_SETTLE:   r_cfg.settle_steps   <= i_cfg_data[15:0];
                pwt_pkg::CFG_EVAL:     r_cfg.eval_steps     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_i_valid <= i_in_valid;
        end
    end

    // squared error is formed on the way in, off the tuner loop
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_i_cmd <= i_in_data.command;
            r_i_err <= i_in_data.error_sample;
            r_i_sq  <= w_sq_full;
        end
    end

    pwt_tuner u_tuner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (w_i_adv),
        .i_cmd    (r_i_cmd),
        .i_err    (r_i_err),
        .i_sq     (r_i_sq),
        .i_cfg    (r_cfg),
        .i_cfg_wr (w_cfg_wr),
        .o_gain   (w_gain),
        .o_integ  (w_integ),
        .o_diff   (w_diff),
        .o_status (w_status)
    );

    pwt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_i_adv),
        .i_cmd       (r_i_cmd),
        .i_err       (r_i_err),
        .i_diff      (w_diff),
        .i_gain      (w_gain),
        .i_integ     (w_integ),
        .i_done      (w_status.done),
        .o_ready     (w_a_ready),
        .o_valid     (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (o_out_data)
    );

    `PWT_ASSERT_NEXT(a_init_refresh, i_clk, i_rst_n, w_i_adv && (r_i_cmd == pwt_pkg::CMD_INIT), w_status.stale, "initialize request did not hold the tuner for refresh")
    `PWT_ASSERT_NEXT(a_cfg_refresh, i_clk, i_rst_n, w_cfg_wr, w_status.stale && !w_i_adv, "config write did not hold the tuner for refresh")
    `PWT_ASSERT_NEXT(a_hold_request, i_clk, i_rst_n, r_i_valid && !w_i_adv, r_i_valid && $stable(r_i_err) && $stable(r_i_cmd), "waiting request changed before its update")
    `PWT_ASSERT_NOW(a_in_wait, i_clk, i_rst_n, r_i_valid && !w_a_ready, !o_in_ready, "request taken while the pipeline was full")

endmodule
